// ===== rtl/nbpe_pkg.sv =====
package nbpe_pkg;

  // Input transaction payload
  typedef struct packed {
    logic signed [31:0] x_first;
    logic signed [31:0] y_first;
    logic signed [31:0] z_first;
    logic signed [31:0] x_second;
    logic signed [31:0] y_second;
    logic signed [31:0] z_second;
    logic [47:0]        lj_repulsive;
    logic [39:0]        lj_attractive;
    logic signed [23:0] charge_first;
    logic signed [23:0] charge_second;
    logic               pair_excluded;
    logic               last_pair;
  } pair_in_t;

  // Output transaction payload
  typedef struct packed {
    logic signed [63:0] vdw_energy;
    logic signed [63:0] elec_energy;
    logic               saturated;
  } result_t;

  // Pre-classified pair handed from front to back
  typedef struct packed {
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [47:0] lj_a;
    logic [39:0] lj_b;
    logic [46:0] qq_mag;
    logic        qq_neg;
    logic        excluded;
    logic        last;
  } pair_job_t;

  typedef struct packed {
    logic      valid;
    pair_job_t job;
  } job_push_t;

  localparam int QDEPTH = 2;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  // Shared multiply unit request and response
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  shift;
    logic [63:0] cap;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic        ovf;
  } mul_rsp_t;

  localparam logic [5:0] SH_8  = 6'd8;
  localparam logic [5:0] SH_16 = 6'd16;
  localparam logic [5:0] SH_24 = 6'd24;
  localparam logic [5:0] SH_32 = 6'd32;
  localparam logic [5:0] SH_48 = 6'd48;

  localparam logic [31:0] COULOMB_RESET    = 32'd21761373;
  localparam int          ENERGY_WIDTH_DEF = 64;

endpackage

// ===== rtl/nbpe_mul.sv =====
module nbpe_mul import nbpe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0]  a;
  logic [63:0]  b;
  logic [63:0]  cap;
  logic [5:0]   sh;
  logic [2:0]   phase;
  logic         busy;
  logic [63:0]  prod;
  logic [127:0] acc;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [127:0] prod_ext;
  logic [127:0] shifted;
  logic         hi_nz;
  logic         over;

  // Pick the partial product for this phase
  always_comb begin
    case (phase[1:0])
      2'd0: begin op_a = a[31:0];  op_b = b[31:0];  end
      2'd1: begin op_a = a[31:0];  op_b = b[63:32]; end
      2'd2: begin op_a = a[63:32]; op_b = b[31:0];  end
      default: begin op_a = a[63:32]; op_b = b[63:32]; end
    endcase
  end

  // Align the product registered in the previous phase
  always_comb begin
    case (phase)
      3'd1:      prod_ext = 128'(prod);
      3'd2, 3'd3: prod_ext = 128'(prod) << 32;
      3'd4:      prod_ext = 128'(prod) << 64;
      default:   prod_ext = '0;
    endcase
  end

  // Shift, then cap
  always_comb begin
    shifted = acc >> sh;
    hi_nz   = (acc >> (7'd64 + 7'(sh))) != '0;
    over    = hi_nz || (shifted[63:0] > cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      phase    <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= !req.start && busy && (phase == 3'd5);
      if (req.start) begin
        a     <= req.a;
        b     <= req.b;
        sh    <= req.shift;
        cap   <= req.cap;
        acc   <= '0;
        phase <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (phase < 3'd4) begin
          prod <= 64'(op_a) * 64'(op_b);
        end
        acc   <= acc + prod_ext;
        phase <= phase + 3'd1;
        if (phase == 3'd5) begin
          rsp.res  <= over ? cap : shifted[63:0];
          rsp.ovf  <= over;
          busy     <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/nbpe_front.sv =====
module nbpe_front import nbpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  pair_in_t    in_data,
  input  queue_stat_t q_stat,
  output job_push_t   push
);

  logic               held;
  pair_job_t          job;
  pair_job_t          job_next;
  logic               take;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] dz;
  logic signed [47:0] qq;

  assign in_stall = held && q_stat.full;
  assign take     = in_valid && !in_stall;

  // Classify the pair: axis distances and charge product
  always_comb begin
    dx = 33'(in_data.x_first) - 33'(in_data.x_second);
    dy = 33'(in_data.y_first) - 33'(in_data.y_second);
    dz = 33'(in_data.z_first) - 33'(in_data.z_second);
    qq = 48'(in_data.charge_first) * 48'(in_data.charge_second);
    job_next.dx       = dx[32] ? 32'(-dx) : 32'(dx);
    job_next.dy       = dy[32] ? 32'(-dy) : 32'(dy);
    job_next.dz       = dz[32] ? 32'(-dz) : 32'(dz);
    job_next.lj_a     = in_data.lj_repulsive;
    job_next.lj_b     = in_data.lj_attractive;
    job_next.qq_mag   = qq[47] ? 47'(-qq) : 47'(qq);
    job_next.qq_neg   = qq[47];
    job_next.excluded = in_data.pair_excluded;
    job_next.last     = in_data.last_pair;
  end

  // Hold one classified pair until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (!q_stat.full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= job_next;
    end
  end

  assign push.valid = held;
  assign push.job   = job;

endmodule

// ===== rtl/nbpe_queue.sv =====
module nbpe_queue import nbpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_push_t   push,
  input  logic        pop,
  output queue_stat_t stat,
  output pair_job_t   head
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  pair_job_t         slots [QDEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              wr;
  logic              rd;

  assign stat.count = count;
  assign stat.valid = count != '0;
  assign stat.full  = count == QCNT_W'(QDEPTH);
  assign wr         = push.valid && !stat.full;
  assign rd         = pop && stat.valid;
  assign head       = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr && !rd) begin
        count <= count + QCNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= push.job;
    end
  end

endmodule

// ===== rtl/nbpe_back.sv =====
module nbpe_back import nbpe_pkg::*; #(
  parameter int ENERGY_WIDTH = ENERGY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_en,
  input  logic [31:0] cfg_data,
  input  queue_stat_t q_stat,
  input  pair_job_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data
);

  localparam int EW = ENERGY_WIDTH;
  localparam logic [63:0] CAP_E = 64'((65'd1 << (EW - 1)) - 65'd1);
  localparam logic [63:0] CAP_M = '1;
  localparam logic signed [EW+1:0] SUM_HI = {3'b000, {(EW - 1){1'b1}}};
  localparam logic signed [EW+1:0] SUM_LO = {3'b111, {(EW - 1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]  state;
  pair_job_t   job;
  logic [2:0]  op;
  logic        pend;
  logic        emit;
  logic [31:0] coulomb;
  logic [63:0] r2;
  logic [63:0] r2_sum;
  logic [63:0] r;
  logic [63:0] inv2;
  logic [63:0] invr;
  logic [63:0] inv4;
  logic [63:0] inv6;
  logic [63:0] f6;
  logic [63:0] a6;
  logic [63:0] f12;
  logic [63:0] pq;
  logic [63:0] mag;
  logic        flag;
  logic signed [EW-1:0] vdw_sum;
  logic signed [EW-1:0] elec_sum;

  logic [63:0] sq_v;
  logic [63:0] sq_res;
  logic [4:0]  sq_cnt;
  logic [63:0] sq_bit;
  logic [63:0] sq_try;
  logic        sq_ge;
  logic [63:0] sq_res_next;

  logic [63:0] dv_rem;
  logic [63:0] dv_q;
  logic [63:0] dv_den;
  logic [5:0]  dv_cnt;
  logic        dv_sel;
  logic [64:0] dv_t;
  logic        dv_ge;
  logic [63:0] dv_q_next;

  logic signed [EW:0]   vdw_v;
  logic signed [EW:0]   elec_v;
  logic [EW:0]          mag_t;
  logic signed [EW+1:0] vdw_s;
  logic signed [EW+1:0] elec_s;
  logic                 vdw_ovf;
  logic                 elec_ovf;
  logic [EW-1:0]        vdw_new;
  logic [EW-1:0]        elec_new;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  nbpe_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign pop    = (state == S_IDLE) && q_stat.valid;
  assign r2_sum = r2 + mrsp.res;
  assign emit   = (state == S_DONE) && job.last && (!out_valid || !out_stall);

  // Issue multiply operands for the current step
  always_comb begin
    mreq.start = ((state == S_SQ) || (state == S_MUL)) && !pend;
    mreq.shift = SH_32;
    mreq.cap   = CAP_M;
    mreq.a     = inv2;
    mreq.b     = inv2;
    if (state == S_SQ) begin
      mreq.shift = SH_8;
      case (op)
        3'd0:    mreq.a = 64'(job.dx);
        3'd1:    mreq.a = 64'(job.dy);
        default: mreq.a = 64'(job.dz);
      endcase
      mreq.b = mreq.a;
    end else begin
      case (op)
        3'd0: ;
        3'd1: mreq.a = inv4;
        3'd2: begin mreq.a = 64'(job.lj_b); mreq.b = inv6; mreq.shift = SH_24;
                    mreq.cap = CAP_E; end
        3'd3: begin mreq.a = 64'(job.lj_a); mreq.b = inv6; mreq.shift = SH_16; end
        3'd4: begin mreq.a = a6; mreq.b = inv6; mreq.cap = CAP_E; end
        3'd5: begin mreq.a = 64'(job.qq_mag); mreq.b = 64'(coulomb); end
        default: begin mreq.a = pq; mreq.b = invr; mreq.shift = SH_48;
                       mreq.cap = CAP_E; end
      endcase
    end
  end

  // One square-root digit per cycle
  always_comb begin
    sq_bit      = 64'd1 << {sq_cnt, 1'b0};
    sq_try      = sq_res + sq_bit;
    sq_ge       = sq_v >= sq_try;
    sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
  end

  // One quotient bit per cycle; the dividend is all ones
  always_comb begin
    dv_t      = {dv_rem, 1'b1};
    dv_ge     = dv_t >= {1'b0, dv_den};
    dv_q_next = {dv_q[62:0], dv_ge};
  end

  // Saturating accumulation of both terms
  always_comb begin
    vdw_v  = (EW + 1)'(f12) - (EW + 1)'(f6);
    mag_t  = (EW + 1)'(mag);
    elec_v = job.qq_neg ? -mag_t : mag_t;
    vdw_s  = (EW + 2)'(vdw_sum) + (EW + 2)'(vdw_v);
    elec_s = (EW + 2)'(elec_sum) + (EW + 2)'(elec_v);
    vdw_ovf  = (vdw_s > SUM_HI) || (vdw_s < SUM_LO);
    elec_ovf = (elec_s > SUM_HI) || (elec_s < SUM_LO);
    vdw_new  = (vdw_s > SUM_HI) ? SUM_HI[EW-1:0] :
               (vdw_s < SUM_LO) ? SUM_LO[EW-1:0] : vdw_s[EW-1:0];
    elec_new = (elec_s > SUM_HI) ? SUM_HI[EW-1:0] :
               (elec_s < SUM_LO) ? SUM_LO[EW-1:0] : elec_s[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coulomb <= COULOMB_RESET;
    end else if (cfg_en) begin
      coulomb <= cfg_data;
    end
  end

  // Sequence one pair through the shared units
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      op        <= '0;
      flag      <= 1'b0;
      vdw_sum   <= '0;
      elec_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_stat.valid) begin
            job   <= head;
            op    <= '0;
            pend  <= 1'b0;
            r2    <= '0;
            state <= head.excluded ? S_DONE : S_SQ;
          end
        end
        S_SQ: begin
          pend <= !mrsp.done;
          if (mrsp.done) begin
            r2   <= r2_sum;
            op   <= (op == 3'd2) ? '0 : op + 3'd1;
            if (op == 3'd2) begin
              if (r2_sum == '0) begin
                flag  <= 1'b1;
                state <= S_DONE;
              end else begin
                sq_v   <= r2_sum;
                sq_res <= '0;
                sq_cnt <= '1;
                state  <= S_SQRT;
              end
            end
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v <= sq_v - sq_try;
          end
          sq_res <= sq_res_next;
          sq_cnt <= sq_cnt - 5'd1;
          if (sq_cnt == '0) begin
            r      <= sq_res_next;
            dv_den <= r2;
            dv_sel <= 1'b0;
            dv_rem <= '0;
            dv_q   <= '0;
            dv_cnt <= '1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_cnt != '0) begin
            dv_rem <= dv_ge ? 64'(dv_t - {1'b0, dv_den}) : dv_t[63:0];
            dv_q   <= dv_q_next;
            dv_cnt <= dv_cnt - 6'd1;
          end else if (!dv_sel) begin
            inv2   <= dv_q_next;
            dv_sel <= 1'b1;
            dv_den <= r;
            dv_rem <= '0;
            dv_q   <= '0;
            dv_cnt <= '1;
          end else begin
            invr  <= dv_q_next;
            op    <= '0;
            pend  <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          pend <= !mrsp.done;
          if (mrsp.done) begin
            flag <= flag | mrsp.ovf;
            case (op)
              3'd0:    inv4 <= mrsp.res;
              3'd1:    inv6 <= mrsp.res;
              3'd2:    f6   <= mrsp.res;
              3'd3:    a6   <= mrsp.res;
              3'd4:    f12  <= mrsp.res;
              3'd5:    pq   <= mrsp.res;
              default: mag  <= mrsp.res;
            endcase
            op    <= op + 3'd1;
            state <= (op == 3'd6) ? S_ADD : S_MUL;
          end
        end
        S_ADD: begin
          vdw_sum  <= vdw_new;
          elec_sum <= elec_new;
          flag     <= flag | vdw_ovf | elec_ovf;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!job.last) begin
            state <= S_IDLE;
          end else if (emit) begin
            out_data.vdw_energy  <= 64'(vdw_sum);
            out_data.elec_energy <= 64'(elec_sum);
            out_data.saturated   <= flag;
            vdw_sum              <= '0;
            elec_sum             <= '0;
            flag                 <= 1'b0;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/nonbonded_pair_energy_accumulator.sv =====
// Channel   Direction  Payload    Handshake
// in        input      pair_in_t  in_valid / in_stall
// out       output     result_t   out_valid / out_stall
// cfg       input      32-bit     cfg_en / cfg_data (coulomb_factor)
//
// An included pair takes three squares and seven capped products on the
// shared multiply unit (64-bit operands, built on one 32x32 multiplier), a 32-step
// square root and two 64-step divisions, then the accumulate step.
// An excluded pair skips the arithmetic. The front and a two-entry queue
// keep taking pairs while the back works. Reset is synchronous; it clears
// the sums, the sticky flag and coulomb_factor to its default.
// A stalled result holds the back on a last pair only.
module nonbonded_pair_energy_accumulator import nbpe_pkg::*; #(
  parameter int ENERGY_WIDTH = ENERGY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  pair_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data,
  input  logic        cfg_en,
  input  logic [31:0] cfg_data
);

  job_push_t   push;
  queue_stat_t q_stat;
  pair_job_t   head;
  logic        pop;

  nbpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push)
  );

  nbpe_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .stat (q_stat),
    .head (head)
  );

  nbpe_back #(
    .ENERGY_WIDTH (ENERGY_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue occupancy beyond depth");

  // Back only pops a non-empty queue
  assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.valid)
    else $error("pop from empty queue");

  // No result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
